// ----- hw/rtl/itaf_pkg.sv -----
// Package for the integer to ASCII formatter: beat types, mode codes,
// character constants and the digit and text lookup functions.
// No dependencies.
`default_nettype none

package itaf_pkg;

    // Formatting modes carried in the opcode field.
    typedef enum logic [1:0] {
        OP_DEC    = 2'd0,
        OP_HEX_LO = 2'd1,
        OP_HEX_UP = 2'd2,
        OP_PTR    = 2'd3
    } itaf_op_t;

    // Input beat: a mode and the number to format.
    typedef struct packed {
        itaf_op_t    opcode;
        logic [63:0] value;
    } itaf_num_t;

    // Output beat: one character of the text.
    typedef struct packed {
        logic [6:0] char_code;
        logic       is_last;
        logic [4:0] char_count;
    } itaf_txt_t;

    localparam int unsigned DEC_BITS    = 32;
    localparam int unsigned BCD_DIGITS  = 10;
    localparam int unsigned HEX_NIBBLES = 16;

    localparam logic [4:0] PREFIX_LEN = 5'd2;
    localparam logic [4:0] NIL_LEN    = 5'd5;
    localparam logic [4:0] MAX_DIGITS = 5'd16;

    localparam logic [6:0] CHAR_ZERO     = 7'd48;  // '0'
    localparam logic [6:0] CHAR_X        = 7'd120; // 'x'
    localparam logic [6:0] CHAR_UP_BASE  = 7'd55;  // 'A' minus ten
    localparam logic [6:0] CHAR_LO_BASE  = 7'd87;  // 'a' minus ten
    localparam logic [6:0] CHAR_LPAREN   = 7'd40;  // '('
    localparam logic [6:0] CHAR_N        = 7'd110; // 'n'
    localparam logic [6:0] CHAR_I        = 7'd105; // 'i'
    localparam logic [6:0] CHAR_L        = 7'd108; // 'l'
    localparam logic [6:0] CHAR_RPAREN   = 7'd41;  // ')'

    // ASCII code of one hex or decimal digit.
    function automatic logic [6:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [6:0] code;
        begin
            if (nib < 4'd10)
            begin
                code = CHAR_ZERO + {3'b000, nib};
            end
            else if (upper)
            begin
                code = CHAR_UP_BASE + {3'b000, nib};
            end
            else
            begin
                code = CHAR_LO_BASE + {3'b000, nib};
            end
            return code;
        end
    endfunction

    // Characters of the text shown for a null pointer.
    function automatic logic [6:0] nil_char(input logic [2:0] idx);
        logic [6:0] code;
        begin
            unique case (idx)
                3'd0:    code = CHAR_LPAREN;
                3'd1:    code = CHAR_N;
                3'd2:    code = CHAR_I;
                3'd3:    code = CHAR_L;
                3'd4:    code = CHAR_RPAREN;
                default: code = CHAR_RPAREN;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// Top level of the integer to ASCII formatter: one sequencer around a shared
// shift-add-3 and nibble shift unit. Depends on itaf_pkg.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+---------------------------------
//   num     | in  | num_valid/num_ready | itaf_num_t: opcode, value
//   txt     | out | txt_valid/txt_ready | itaf_txt_t: char_code, is_last,
//           |     |                     |             char_count
//
// Decimal mode first takes 32 shift-add-3 steps, one input bit per cycle. Then 16 digit
// slots pass: one strip step per leading zero, one to settle, one per digit.
// A pointer adds a 0x prefix; a null pointer sends five characters, one a cycle if unstalled.
// num_ready is high only while idle; a stalled character holds the sequencer until it moves.
// rst_n clears the sequencer and the output valid flag asynchronously.
`default_nettype none

module integer_to_ascii_formatter (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       num_valid,
    output logic                      num_ready,
    input  wire itaf_pkg::itaf_num_t  num,
    output logic                      txt_valid,
    input  wire                       txt_ready,
    output itaf_pkg::itaf_txt_t       txt
);
    import itaf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_PREFIX,
        ST_DIGITS,
        ST_NIL
    } state_t;

    localparam int unsigned BCD_BITS = 4 * BCD_DIGITS;

    state_t      state_reg, state_next;
    logic [63:0] digits_reg, digits_next;
    logic [31:0] bin_reg, bin_next;
    logic [4:0]  step_reg, step_next;
    logic [4:0]  ndig_reg, ndig_next;
    logic [4:0]  total_reg, total_next;
    logic [2:0]  pos_reg, pos_next;
    logic        upper_reg, upper_next;
    logic        ptr_reg, ptr_next;
    logic        out_valid_reg, out_valid_next;
    itaf_txt_t   out_reg, out_next;

    logic                  accept;
    logic                  slot_free;
    logic [BCD_BITS-1:0]   bcd_adj;

    assign accept    = num_valid && num_ready;
    assign slot_free = !out_valid_reg || txt_ready;

    // Shift-add-3 correction on every BCD digit ahead of the shift.
    always_comb
    begin
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (digits_reg[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = digits_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = digits_reg[4*d +: 4];
            end
        end
    end

    // Sequencer next-state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        bin_next       = bin_reg;
        step_next      = step_reg;
        ndig_next      = ndig_reg;
        total_next     = total_reg;
        pos_next       = pos_reg;
        upper_next     = upper_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !txt_ready;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    upper_next = (num.opcode == OP_HEX_UP);
                    ptr_next   = (num.opcode == OP_PTR);
                    ndig_next  = MAX_DIGITS;
                    pos_next   = 3'd0;
                    unique case (num.opcode)
                        OP_DEC:
                        begin
                            bin_next    = num.value[31:0];
                            digits_next = '0;
                            step_next   = 5'(DEC_BITS - 1);
                            state_next  = ST_CONV;
                        end
                        OP_HEX_LO, OP_HEX_UP:
                        begin
                            digits_next = {32'h0, num.value[31:0]};
                            state_next  = ST_STRIP;
                        end
                        OP_PTR:
                        begin
                            digits_next = num.value;
                            if (num.value == 64'h0)
                            begin
                                state_next = ST_NIL;
                            end
                            else
                            begin
                                state_next = ST_STRIP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CONV:
            begin
                digits_next = {24'h0, bcd_adj[BCD_BITS-2:0], bin_reg[31]};
                bin_next    = {bin_reg[30:0], 1'b0};
                step_next   = step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    state_next = ST_STRIP;
                end
            end

            ST_STRIP:
            begin
                // Drop leading zero digits but keep at least one.
                if (digits_reg[63:60] == 4'h0 && ndig_reg != 5'd1)
                begin
                    digits_next = {digits_reg[59:0], 4'h0};
                    ndig_next   = ndig_reg - 5'd1;
                end
                else
                begin
                    total_next = ptr_reg ? (ndig_reg + PREFIX_LEN) : ndig_reg;
                    state_next = ptr_reg ? ST_PREFIX : ST_DIGITS;
                end
            end

            ST_PREFIX:
            begin
                if (slot_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.char_code   = (pos_reg == 3'd0) ? CHAR_ZERO : CHAR_X;
                    out_next.is_last     = 1'b0;
                    out_next.char_count  = 5'd0;
                    pos_next             = pos_reg + 3'd1;
                    if (pos_reg == 3'd1)
                    begin
                        state_next = ST_DIGITS;
                    end
                end
            end

            ST_DIGITS:
            begin
                if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.char_code  = digit_char(digits_reg[63:60], upper_reg);
                    out_next.is_last    = (ndig_reg == 5'd1);
                    out_next.char_count = (ndig_reg == 5'd1) ? total_reg : 5'd0;
                    digits_next         = {digits_reg[59:0], 4'h0};
                    ndig_next           = ndig_reg - 5'd1;
                    if (ndig_reg == 5'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_NIL:
            begin
                if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.char_code  = nil_char(pos_reg);
                    out_next.is_last    = (pos_reg == 3'(NIL_LEN - 5'd1));
                    out_next.char_count = (pos_reg == 3'(NIL_LEN - 5'd1)) ? NIL_LEN : 5'd0;
                    pos_next            = pos_reg + 3'd1;
                    if (pos_reg == 3'(NIL_LEN - 5'd1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            digits_reg    <= '0;
            bin_reg       <= '0;
            step_reg      <= '0;
            ndig_reg      <= '0;
            total_reg     <= '0;
            pos_reg       <= '0;
            upper_reg     <= 1'b0;
            ptr_reg       <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            digits_reg    <= digits_next;
            bin_reg       <= bin_next;
            step_reg      <= step_next;
            ndig_reg      <= ndig_next;
            total_reg     <= total_next;
            pos_reg       <= pos_next;
            upper_reg     <= upper_next;
            ptr_reg       <= ptr_next;
            out_reg       <= out_next;
        end
    end

    assign num_ready = (state_reg == ST_IDLE);
    assign txt_valid = out_valid_reg;
    assign txt       = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/itaf_check.sv -----
// Port-level checks for the integer to ASCII formatter, bound to the top level.
// Depends on itaf_pkg and integer_to_ascii_formatter.
`default_nettype none

module itaf_check (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       num_valid,
    input wire                       num_ready,
    input wire                       txt_valid,
    input wire                       txt_ready,
    input wire itaf_pkg::itaf_txt_t  txt
);
    import itaf_pkg::*;

    // A stalled character beat holds its payload.
    a_txt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && !txt_ready |=> txt_valid && $stable(txt))
        else $error("txt beat changed while stalled");

    // Only the final character carries a count.
    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && !txt.is_last |-> txt.char_count == 5'd0)
        else $error("count on a non-final character");

    // The final character carries a count from 1 to 18.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && txt.is_last |-> txt.char_count != 5'd0 && txt.char_count <= 5'd18)
        else $error("final count out of range");

    // The block is busy in the cycle after it takes a number.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && num_ready |=> !num_ready)
        else $error("ready right after accepting a number");

endmodule

bind integer_to_ascii_formatter itaf_check u_itaf_check (.*);

`default_nettype wire

// ----- verif/tb_integer_to_ascii_formatter.sv -----
// Testbench for integer_to_ascii_formatter: a table of directed numbers, then
// random numbers, each with an expected text (typed or from a local predictor), checked per beat.
// Depends on itaf_pkg and the formatter RTL.

module tb_integer_to_ascii_formatter;

    import itaf_pkg::*;

    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned MAX_REPORTS  = 10;

    localparam logic [7:0] ASC_ZERO  = "0";
    localparam logic [7:0] ASC_LO_A  = "a";
    localparam logic [7:0] ASC_UP_A  = "A";
    localparam logic [7:0] ASC_X     = "x";

    typedef logic [7:0] text_q_t[$];

    // One directed number; an empty text means the predictor supplies it.
    typedef struct {
        itaf_op_t    op;
        logic [63:0] value;
        string       text;
    } number_row_t;

    logic        clk;
    logic        rst_n;
    logic        num_valid;
    logic        num_ready;
    itaf_num_t   num;
    logic        txt_valid;
    logic        txt_ready;
    itaf_txt_t   txt;

    itaf_txt_t   expected_chars[$];
    int unsigned idle_pct;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    number_row_t directed_rows[22];

    integer_to_ascii_formatter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .txt_valid (txt_valid),
        .txt_ready (txt_ready),
        .txt       (txt)
    );

    always #5 clk = ~clk;

    // Turns a string into a queue of character codes.
    function automatic void text_from_string(input string s, output text_q_t text);
        text = {};
        for (int i = 0; i < s.len(); i++)
        begin
            text.push_back(s[i]);
        end
    endfunction

    // Formats one number the way the block should: digits without leading
    // zeros, and for pointers either the null text or a 0x prefix.
    function automatic void format_number(input itaf_op_t op, input logic [63:0] value,
                                          output text_q_t text);
        logic [63:0] rest;
        logic [63:0] radix;
        logic [63:0] digit;
        logic [7:0]  alpha;
        text = {};
        if (op == OP_PTR && value == 64'd0)
        begin
            text_from_string("(nil)", text);
            return;
        end
        rest  = (op == OP_PTR) ? value : {32'd0, value[31:0]};
        radix = (op == OP_DEC) ? 64'd10 : 64'd16;
        alpha = (op == OP_HEX_UP) ? ASC_UP_A : ASC_LO_A;
        do
        begin
            digit = rest % radix;
            if (digit < 64'd10)
            begin
                text.push_front(ASC_ZERO + digit[7:0]);
            end
            else
            begin
                text.push_front(alpha + digit[7:0] - 8'd10);
            end
            rest = rest / radix;
        end
        while (rest != 64'd0);
        if (op == OP_PTR)
        begin
            text.push_front(ASC_X);
            text.push_front(ASC_ZERO);
        end
    endfunction

    // Queues one beat per character; only the final one carries the count.
    function automatic void expect_text(input text_q_t text);
        itaf_txt_t beat;
        for (int k = 0; k < text.size(); k++)
        begin
            beat.char_code  = text[k][6:0];
            beat.is_last    = (k == text.size() - 1);
            beat.char_count = beat.is_last ? 5'(text.size()) : 5'd0;
            expected_chars.push_back(beat);
        end
    endfunction

    // Random value: mostly random lengths, with zero and all-ones low halves
    // under a random upper half, and an all-ones value, mixed in.
    function automatic logic [63:0] random_value();
        logic [63:0]  v;
        int unsigned  width;
        v     = {$urandom, $urandom};
        width = $urandom_range(64);
        case ($urandom_range(9))
            0:       v = {v[63:32], 32'd0};
            1:       v = {v[63:32], 32'hFFFF_FFFF};
            2:       v = '1;
            default:
            begin
                if (width < 64)
                begin
                    v = v & ((64'd1 << width) - 64'd1);
                end
            end
        endcase
        return v;
    endfunction

    // Offers one number beat, holds it until accepted, then queues its text.
    task automatic send_number(input itaf_num_t beat, input text_q_t text);
        while ($urandom_range(99) < idle_pct)
        begin
            num_valid <= 1'b0;
            @(posedge clk);
        end
        num       <= beat;
        num_valid <= 1'b1;
        @(posedge clk);
        while (!num_ready)
        begin
            @(posedge clk);
        end
        expect_text(text);
    endtask

    // Compares one character beat with the oldest expected one.
    function automatic void check_char(input itaf_txt_t got);
        itaf_txt_t want;
        if (expected_chars.size() == 0)
        begin
            if (mismatch_count < MAX_REPORTS)
            begin
                $display("unexpected character beat: code %0d last %0b count %0d",
                         got.char_code, got.is_last, got.char_count);
            end
            mismatch_count++;
            return;
        end
        want = expected_chars.pop_front();
        if (got !== want)
        begin
            if (mismatch_count < MAX_REPORTS)
            begin
                $display("character mismatch: expected code %0d last %0b count %0d, got code %0d last %0b count %0d",
                         want.char_code, want.is_last, want.char_count,
                         got.char_code, got.is_last, got.char_count);
            end
            mismatch_count++;
        end
    endfunction

    // Receiver side: random back-pressure and the check of each beat.
    always @(posedge clk)
    begin
        txt_ready <= ($urandom_range(99) >= idle_pct);
        if (rst_n && txt_valid && txt_ready)
        begin
            check_char(txt);
        end
    end

    // Watchdog on cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if ((num_valid && num_ready) || (txt_valid && txt_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat moved in %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random numbers, drain.
    initial
    begin
        itaf_num_t beat;
        text_q_t   text;

        clk            = 1'b0;
        rst_n          = 1'b0;
        num_valid      = 1'b0;
        num            = '0;
        txt_ready      = 1'b0;
        idle_pct       = 29;
        mismatch_count = 0;
        quiet_cycles   = 0;

        directed_rows = '{
            '{OP_DEC,    64'd0,                     "0"},
            '{OP_DEC,    64'h0000_0000_FFFF_FFFF,   "4294967295"},
            '{OP_DEC,    64'hFFFF_FFFF_0000_0000,   "0"},
            '{OP_DEC,    64'hDEAD_BEEF_0000_000A,   "10"},
            '{OP_DEC,    64'd9,                     "9"},
            '{OP_HEX_LO, 64'd0,                     "0"},
            '{OP_HEX_LO, 64'h0000_0000_FFFF_FFFF,   "ffffffff"},
            '{OP_HEX_LO, 64'hFFFF_FFFF_0000_0000,   "0"},
            '{OP_HEX_LO, 64'h1234_5678_89AB_CDEF,   "89abcdef"},
            '{OP_HEX_UP, 64'd0,                     "0"},
            '{OP_HEX_UP, 64'h0000_0000_FFFF_FFFF,   "FFFFFFFF"},
            '{OP_HEX_UP, 64'h0000_0001_89AB_CDEF,   "89ABCDEF"},
            '{OP_HEX_UP, 64'd10,                    "A"},
            '{OP_PTR,    64'd0,                     "(nil)"},
            '{OP_PTR,    64'hFFFF_FFFF_FFFF_FFFF,   "0xffffffffffffffff"},
            '{OP_PTR,    64'd1,                     "0x1"},
            '{OP_PTR,    64'h0000_0001_0000_0000,   "0x100000000"},
            '{OP_PTR,    64'h8000_0000_0000_0000,   "0x8000000000000000"},
            '{OP_DEC,    64'd1000000000,            ""},
            '{OP_HEX_LO, 64'h0000_0000_0000_F00D,   ""},
            '{OP_PTR,    64'h0000_7FFF_DEAD_BEEF,   ""},
            '{OP_DEC,    64'd4294967,               ""}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: typed text where it is obvious, predictor elsewhere.
        foreach (directed_rows[r])
        begin
            beat.opcode = directed_rows[r].op;
            beat.value  = directed_rows[r].value;
            if (directed_rows[r].text.len() != 0)
            begin
                text_from_string(directed_rows[r].text, text);
            end
            else
            begin
                format_number(beat.opcode, beat.value, text);
            end
            send_number(beat, text);
        end

        // Random part, with a stretch where neither side idles.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_pct    = (n >= 200 && n < 300) ? 0 : 29;
            beat.opcode = itaf_op_t'($urandom_range(3));
            beat.value  = random_value();
            format_number(beat.opcode, beat.value, text);
            send_number(beat, text);
        end
        num_valid <= 1'b0;

        // Wait for the last characters, then watch for stray beats.
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/itaf_pkg.sv
hw/rtl/integer_to_ascii_formatter.sv
hw/rtl/itaf_check.sv
verif/tb_integer_to_ascii_formatter.sv
